FILE: src/ppcc_pkg.sv
// ----------------------------------------------------------------------------
// ppcc_pkg: shared types and constants for the path pair conflict checker
// Item and result layouts, collision kind codes, default cell width.
// ----------------------------------------------------------------------------
package ppcc_pkg;

  localparam int LOC_BITS          = 20;
  localparam int CELL_BITS_DEFAULT = 20;
  localparam int KIND_BITS         = 2;
  localparam int S_TDATA_BITS      = 48;
  localparam int M_TDATA_BITS      = 8;

  localparam logic [KIND_BITS-1:0] KIND_NONE        = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_VERTEX_EDGE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TARGET      = 2'd2;

  typedef struct packed {
    logic                last;
    logic                has_b;
    logic                has_a;
    logic [LOC_BITS-1:0] loc_b;
    logic [LOC_BITS-1:0] loc_a;
  } item_t;

  typedef struct packed {
    logic                 second_named_first;
    logic [KIND_BITS-1:0] kind;
    logic                 collides;
  } result_t;

endpackage

FILE: src/ppcc_core.sv
// ----------------------------------------------------------------------------
// ppcc_core: per-timestep collision checks and pair state
// Compares the current item against the previous timestep and the held goal,
// updates the pair state on each step and forms the verdict at the last item.
// ----------------------------------------------------------------------------
module ppcc_core #(
  parameter int CELL_BITS = ppcc_pkg::CELL_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ppcc_pkg::item_t   item,
  output ppcc_pkg::result_t result
);

  localparam int CW = (CELL_BITS < ppcc_pkg::LOC_BITS) ? CELL_BITS : ppcc_pkg::LOC_BITS;

  logic [CW-1:0] prev_cell_a;
  logic [CW-1:0] prev_cell_b;
  logic          prev_present_a;
  logic          prev_present_b;
  logic          have_previous;
  logic [CW-1:0] goal_cell;
  logic          goal_held;
  logic          goal_owner_b;
  logic          hit_vertex_edge;
  logic          hit_target;

  logic [CW-1:0] ca;
  logic [CW-1:0] cb;
  logic          pa;
  logic          pb;
  logic          both_prev;
  logic          cap_a;
  logic          cap_b;
  logic [CW-1:0] goal_cell_next;
  logic          goal_held_next;
  logic          goal_owner_b_next;
  logic          hit_vertex_edge_next;
  logic          hit_target_next;
  logic          tgt_now;

  assign ca = item.loc_a[CW-1:0];
  assign cb = item.loc_b[CW-1:0];
  assign pa = item.has_a;
  assign pb = item.has_b;
  assign both_prev = have_previous & prev_present_a & prev_present_b;

  assign cap_a = both_prev & ~goal_held & ~pa & pb;
  assign cap_b = both_prev & ~goal_held & pa & ~pb;

  always_comb begin
    goal_held_next    = goal_held | cap_a | cap_b;
    goal_owner_b_next = cap_b ? 1'b1 : (cap_a ? 1'b0 : goal_owner_b);
    goal_cell_next    = cap_a ? prev_cell_a : (cap_b ? prev_cell_b : goal_cell);
    hit_vertex_edge_next = hit_vertex_edge |
      (both_prev & pa & pb &
       ((prev_cell_a == prev_cell_b) | ((prev_cell_a == cb) & (prev_cell_b == ca))));
    // longer path on the goal cell at the current timestep
    tgt_now = goal_owner_b_next ? (pa & (ca == goal_cell_next))
                                : (pb & (cb == goal_cell_next));
    hit_target_next = hit_target | ((cap_a | cap_b) & (prev_cell_a == prev_cell_b)) |
                      (goal_held_next & tgt_now);
  end

  always_comb begin
    result.collides           = hit_target_next | hit_vertex_edge_next;
    result.second_named_first = hit_target_next & goal_owner_b_next;
    if (hit_target_next) begin
      result.kind = ppcc_pkg::KIND_TARGET;
    end else if (hit_vertex_edge_next) begin
      result.kind = ppcc_pkg::KIND_VERTEX_EDGE;
    end else begin
      result.kind = ppcc_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      prev_cell_a     <= '0;
      prev_cell_b     <= '0;
      prev_present_a  <= 1'b0;
      prev_present_b  <= 1'b0;
      have_previous   <= 1'b0;
      goal_cell       <= '0;
      goal_held       <= 1'b0;
      goal_owner_b    <= 1'b0;
      hit_vertex_edge <= 1'b0;
      hit_target      <= 1'b0;
    end else if (step) begin
      prev_cell_a     <= ca;
      prev_cell_b     <= cb;
      prev_present_a  <= pa;
      prev_present_b  <= pb;
      have_previous   <= 1'b1;
      goal_cell       <= goal_cell_next;
      goal_held       <= goal_held_next;
      goal_owner_b    <= goal_owner_b_next;
      hit_vertex_edge <= hit_vertex_edge_next;
      hit_target      <= hit_target_next;
    end
  end

endmodule

FILE: src/ppcc_out_reg.sv
// ----------------------------------------------------------------------------
// ppcc_out_reg: result register on the master side
// Holds one verdict until the sink takes it; accepts a new one on the cycle
// the held one leaves.
// ----------------------------------------------------------------------------
module ppcc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ppcc_pkg::result_t result,
  output logic              room,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [ppcc_pkg::M_TDATA_BITS-1:0] m_tdata
);

  ppcc_pkg::result_t held;
  logic              held_valid;

  assign room     = ~held_valid | m_tready;
  assign m_tvalid = held_valid;
  assign m_tdata  = {{(ppcc_pkg::M_TDATA_BITS - $bits(ppcc_pkg::result_t)){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (m_tready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

FILE: src/path_pair_conflict_check.sv
// ----------------------------------------------------------------------------
// path_pair_conflict_check: vertex, edge and target collision check
// Streams two timed paths one timestep per transfer and reports one verdict
// per pair at the transfer marked tlast.
// ----------------------------------------------------------------------------
// One timestep is taken every cycle unless a last one waits for room. A
// transfer is captured in an input register and checked against the
// previous timestep and the held goal; a pair's verdict is registered in the
// result register when its tlast item steps. Only the result register stalls
// the input: while a verdict waits on m_tready, non-last timesteps flow on.
module path_pair_conflict_check #(
  parameter int CELL_BITS = ppcc_pkg::CELL_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // loc_a [19:0], loc_b [39:20], has_a [40], has_b [41], zero [47:42]
  input  logic [ppcc_pkg::S_TDATA_BITS-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // collides [0], kind [2:1], second_named_first [3], zero [7:4]
  output logic [ppcc_pkg::M_TDATA_BITS-1:0] m_tdata
);

  localparam int LB = ppcc_pkg::LOC_BITS;

  ppcc_pkg::item_t   item;
  logic              item_valid;
  ppcc_pkg::result_t result;
  logic              room;
  logic              step;

  assign step     = item_valid & (~item.last | room);
  assign s_tready = ~rst & (~item_valid | step);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.loc_a <= s_tdata[LB-1:0];
      item.loc_b <= s_tdata[2*LB-1:LB];
      item.has_a <= s_tdata[2*LB];
      item.has_b <= s_tdata[2*LB+1];
      item.last  <= s_tlast;
    end
  end

  ppcc_core #(
    .CELL_BITS (CELL_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  ppcc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step & item.last),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for path_pair_conflict_check
// Streams timed path pairs (a short directed table, then random pairs, most
// drawn from small cell pools so that meets, swaps and goal hits are common),
// predicts each pair verdict and compares every result transfer field by
// field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PAD_BITS = ppcc_pkg::S_TDATA_BITS - 2 * ppcc_pkg::LOC_BITS - 2;

  typedef struct {
    ppcc_pkg::item_t   step;
    bit                typed;
    ppcc_pkg::result_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ppcc_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ppcc_pkg::M_TDATA_BITS-1:0] m_tdata;

  // predicted pair state
  logic [ppcc_pkg::LOC_BITS-1:0] prev_a, prev_b, goal;
  bit prev_has_a, prev_has_b, seen_prev, goal_valid, goal_from_b;
  bit meet_hit, target_hit;

  ppcc_pkg::result_t verdicts_due[$];
  table_row_t        steps_plan[$];
  int mismatches = 0;
  int items_sent = 0;

  path_pair_conflict_check dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_track();
    prev_a = '0;
    prev_b = '0;
    goal = '0;
    prev_has_a = 1'b0;
    prev_has_b = 1'b0;
    seen_prev = 1'b0;
    goal_valid = 1'b0;
    goal_from_b = 1'b0;
    meet_hit = 1'b0;
    target_hit = 1'b0;
  endfunction

  // advances the pair state by one timestep; returns 1 when a verdict is due
  function automatic bit step_paths(input ppcc_pkg::item_t it,
                                    output ppcc_pkg::result_t verdict);
    verdict = '0;
    if (seen_prev) begin
      if (prev_has_a && prev_has_b && it.has_a && it.has_b &&
          (prev_a == prev_b || (prev_a == it.loc_b && prev_b == it.loc_a)))
        meet_hit = 1'b1;
      if (!goal_valid && prev_has_a && prev_has_b) begin
        if (!it.has_a && it.has_b) begin
          goal_valid = 1'b1;
          goal_from_b = 1'b0;
          goal = prev_a;
          if (prev_b == goal) target_hit = 1'b1;
        end else if (it.has_a && !it.has_b) begin
          goal_valid = 1'b1;
          goal_from_b = 1'b1;
          goal = prev_b;
          if (prev_a == goal) target_hit = 1'b1;
        end
      end
    end
    if (goal_valid) begin
      if (goal_from_b) begin
        if (it.has_a && it.loc_a == goal) target_hit = 1'b1;
      end else begin
        if (it.has_b && it.loc_b == goal) target_hit = 1'b1;
      end
    end
    prev_a = it.loc_a;
    prev_b = it.loc_b;
    prev_has_a = it.has_a;
    prev_has_b = it.has_b;
    seen_prev = 1'b1;
    if (!it.last) return 1'b0;
    verdict.collides = target_hit || meet_hit;
    verdict.kind = target_hit ? ppcc_pkg::KIND_TARGET :
                   (meet_hit ? ppcc_pkg::KIND_VERTEX_EDGE : ppcc_pkg::KIND_NONE);
    verdict.second_named_first = target_hit && goal_from_b;
    clear_track();
    return 1'b1;
  endfunction

  task automatic add_row(input logic [ppcc_pkg::LOC_BITS-1:0] loc_a,
                         input logic [ppcc_pkg::LOC_BITS-1:0] loc_b,
                         input bit has_a, input bit has_b, input bit last,
                         input bit typed, input bit collides,
                         input logic [ppcc_pkg::KIND_BITS-1:0] kind, input bit named_b);
    table_row_t row;
    row.step.loc_a = loc_a;
    row.step.loc_b = loc_b;
    row.step.has_a = has_a;
    row.step.has_b = has_b;
    row.step.last = last;
    row.typed = typed;
    row.want.collides = collides;
    row.want.kind = kind;
    row.want.second_named_first = named_b;
    steps_plan.insert(steps_plan.size(), row);
  endtask

  task automatic send_step(input ppcc_pkg::item_t it, input int gap, input bit typed,
                           input ppcc_pkg::result_t want);
    ppcc_pkg::result_t verdict;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{PAD_BITS{1'b0}}, it.has_b, it.has_a, it.loc_b, it.loc_a};
    s_tlast <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (step_paths(it, verdict))
      verdicts_due.insert(verdicts_due.size(), typed ? want : verdict);
    items_sent++;
  endtask

  function automatic logic [ppcc_pkg::LOC_BITS-1:0] pick_cell(
      input logic [ppcc_pkg::LOC_BITS-1:0] base, input int spread);
    if (spread == 0) return ppcc_pkg::LOC_BITS'($urandom);
    return base + ppcc_pkg::LOC_BITS'($urandom_range(0, spread - 1));
  endfunction

  initial begin : stimulus
    ppcc_pkg::item_t it;
    ppcc_pkg::result_t none;
    logic [ppcc_pkg::LOC_BITS-1:0] base;
    int len_a, len_b, span, spread, gap, pairs;
    bit quiet, noisy;

    none = '0;
    clear_track();
    // single timestep pairs, then swaps and meets
    add_row(20'h00000, 20'h00000, 1, 1, 1, 1, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(20'hFFFFF, 20'hFFFFF, 1, 1, 1, 1, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(20'hFFFFF, 20'h00000, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(20'h00000, 20'hFFFFF, 1, 1, 1, 1, 1, ppcc_pkg::KIND_VERTEX_EDGE, 0);
    add_row(5, 5, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(1, 2, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(3, 4, 1, 1, 1, 1, 1, ppcc_pkg::KIND_VERTEX_EDGE, 0);
    // equal lengths: no vertex check at the common final step
    add_row(1, 2, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(7, 7, 1, 1, 1, 1, 0, ppcc_pkg::KIND_NONE, 0);
    // goal hits, first path shorter and second path shorter
    add_row(10, 20, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(11, 21, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(0, 11, 0, 1, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(30, 40, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(40, 0, 1, 0, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);
    // target wins over vertex
    add_row(5, 5, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(6, 7, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(0, 6, 0, 1, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);
    // goal hit at the capture step itself
    add_row(6, 6, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(0, 9, 0, 1, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);
    // both drop together, then nothing present
    add_row(1, 2, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(3, 4, 0, 0, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(3, 3, 0, 0, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);
    // first path drops out and comes back
    add_row(2, 3, 1, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(0, 3, 0, 1, 0, 0, 0, ppcc_pkg::KIND_NONE, 0);
    add_row(3, 2, 1, 1, 1, 0, 0, ppcc_pkg::KIND_NONE, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (steps_plan[i])
      send_step(steps_plan[i].step, $urandom_range(0, 12), steps_plan[i].typed,
                steps_plan[i].want);

    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);

    quiet = 1'b0;
    pairs = 0;
    while (items_sent < 1350) begin
      pairs++;
      if (pairs == 80) begin
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 5) == 0) quiet = !quiet;
      noisy = ($urandom_range(0, 7) == 0);
      len_a = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      if ($urandom_range(0, 3) == 0) len_b = len_a;
      else len_b = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      span = (len_a > len_b) ? len_a : len_b;
      spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      base = ppcc_pkg::LOC_BITS'($urandom);
      for (int t = 0; t < span; t++) begin
        it.loc_a = pick_cell(base, spread);
        it.loc_b = pick_cell(base, spread);
        it.has_a = noisy ? 1'($urandom_range(0, 1)) : (t < len_a);
        it.has_b = noisy ? 1'($urandom_range(0, 1)) : (t < len_b);
        it.last = (t == span - 1);
        gap = quiet ? 0 : $urandom_range(0, 12);
        send_step(it, gap, 1'b0, none);
      end
    end
    s_tvalid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : result_sink
    int stall;
    bit quiet;
    quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : verdict_check
    ppcc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
      end else begin
        want = verdicts_due.pop_front();
        if (m_tdata[0] !== want.collides) begin
          mismatches++;
          $display("%0t: collides expected %0d actual %0d", $time, want.collides,
                   m_tdata[0]);
        end
        if (m_tdata[2:1] !== want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tdata[2:1]);
        end
        if (m_tdata[3] !== want.second_named_first) begin
          mismatches++;
          $display("%0t: second_named_first expected %0d actual %0d", $time,
                   want.second_named_first, m_tdata[3]);
        end
        if (m_tdata[ppcc_pkg::M_TDATA_BITS-1:4] !== '0) begin
          mismatches++;
          $display("%0t: padding expected 0 actual %h", $time,
                   m_tdata[ppcc_pkg::M_TDATA_BITS-1:4]);
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
